FILE: rtl/gpf_pkg.sv
`timescale 1ns / 1ps

package gpf_pkg;

  // Word buffer geometry.
  localparam int WORD_MAX = 32;
  localparam int WORD_AW  = $clog2(WORD_MAX);
  localparam int LEN_W    = $clog2(WORD_MAX + 1);

  // Field widths.
  localparam int CODE_W   = 21;
  localparam int COL_W    = 9;
  localparam int LIMIT_W  = 8;
  localparam int MARGIN_W = 5;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 8;

  // Character codes.
  localparam logic [CODE_W-1:0] CH_SPACE = CODE_W'(32);
  localparam logic [CODE_W-1:0] CH_TAB   = CODE_W'(9);
  localparam logic [CODE_W-1:0] CH_DOT   = CODE_W'(46);

  localparam logic [MARGIN_W-1:0] MARGIN_MAX   = MARGIN_W'(16);
  localparam logic [COL_W-1:0]    NARROW_SLACK = COL_W'(10);

  // Register indexes.
  localparam logic [CFG_IW-1:0] REG_FILL_LIMIT   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_JUSTIFY_MODE = 2'd1;
  localparam logic [CFG_IW-1:0] REG_MARGIN_WIDTH = 2'd2;
  localparam logic [CFG_IW-1:0] REG_START_COLUMN = 2'd3;

  // Reset values of the registers.
  localparam logic [LIMIT_W-1:0]  FILL_LIMIT_RST   = LIMIT_W'(72);
  localparam logic [MARGIN_W-1:0] MARGIN_WIDTH_RST = '0;
  localparam logic [LIMIT_W-1:0]  START_COLUMN_RST = '0;

endpackage

FILE: rtl/gpf_channels.sv
`timescale 1ns / 1ps

interface gpf_in_if;
  logic                       valid;
  logic                       ready;
  logic [gpf_pkg::CODE_W-1:0] char_code;
  logic                       line_end;
  logic                       para_end;

  modport source (output valid, output char_code, output line_end, output para_end,
                  input ready);
  modport sink (input valid, input char_code, input line_end, input para_end,
                output ready);
endinterface

interface gpf_out_if;
  logic                       valid;
  logic                       ready;
  logic [gpf_pkg::CODE_W-1:0] out_code;
  logic                       is_newline;
  logic                       last_of_run;

  modport source (output valid, output out_code, output is_newline, output last_of_run,
                  input ready);
  modport sink (input valid, input out_code, input is_newline, input last_of_run,
                output ready);
endinterface

interface gpf_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [gpf_pkg::CFG_IW-1:0] reg_index;
  logic [gpf_pkg::CFG_DW-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

FILE: rtl/greedy_paragraph_fill.sv
`timescale 1ns / 1ps

// Greedy paragraph filler. Characters arrive one per input beat; word characters
// are collected in a 32-entry word buffer (later characters of a longer word
// are dropped) and give no result. A separator (space, tab, line end or
// paragraph end) that follows a word places it: the separator is accepted, then
// the results pass through the single output register, in order: the leading
// space or newline, margin spaces (justify mode), the word characters read from
// the buffer, the space after a period (fill mode) and the final newline at
// paragraph end. The leading state is passed through even when the first word
// of a paragraph fits and needs no space. Results wait while the output stalls.
// The input is not ready while results are being produced. With filling disabled
// or invalid settings each beat is echoed as one result. Configuration writes
// are always taken and must only be made while idle.
module greedy_paragraph_fill (
  input  logic       clk,
  input  logic       rst_n,
  gpf_in_if.sink     in_if,
  gpf_out_if.source  out_if,
  gpf_cfg_if.sink    cfg_if
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS,
    S_LEAD,
    S_MARGIN,
    S_WORD,
    S_DOT,
    S_PEND
  } state_t;

  state_t state_r;

  logic [gpf_pkg::LIMIT_W-1:0]  fill_r;
  logic                         justify_r;
  logic [gpf_pkg::MARGIN_W-1:0] margin_r;
  logic [gpf_pkg::LIMIT_W-1:0]  start_r;

  logic [gpf_pkg::LEN_W-1:0]    wlen_r;
  logic [gpf_pkg::COL_W-1:0]    col_r;
  logic                         first_r;
  logic                         period_r;

  logic                         pe_r;
  logic                         fits_r;
  logic [gpf_pkg::MARGIN_W-1:0] mcnt_r;
  logic [gpf_pkg::LEN_W-1:0]    emit_idx_r;
  logic [gpf_pkg::LEN_W-1:0]    emit_idx_nxt;
  logic [gpf_pkg::CODE_W-1:0]   pass_code_r;
  logic                         pass_nl_r;

  logic                         out_valid_r;
  logic [gpf_pkg::CODE_W-1:0]   out_code_r;
  logic                         out_nl_r;
  logic                         out_last_r;

  logic [gpf_pkg::CODE_W-1:0]   word_mem [gpf_pkg::WORD_MAX];
  logic [gpf_pkg::CODE_W-1:0]   rd_data_r;

  logic in_fire;
  logic out_free;
  logic line_end;
  logic is_sep;
  logic settings_ok;
  logic word_we;
  logic dot_needed;
  logic word_last;
  logic fits;
  logic [gpf_pkg::COL_W:0] fit_sum;
  logic [gpf_pkg::COL_W-1:0] margin_sum;

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_fire      = in_if.valid && in_if.ready;
  assign out_free     = !out_valid_r || out_if.ready;

  assign out_if.valid       = out_valid_r;
  assign out_if.out_code    = out_code_r;
  assign out_if.is_newline  = out_nl_r;
  assign out_if.last_of_run = out_last_r;

  assign line_end = in_if.line_end || in_if.para_end;
  assign is_sep   = line_end || (in_if.char_code == gpf_pkg::CH_SPACE) ||
                    (in_if.char_code == gpf_pkg::CH_TAB);

  assign margin_sum  = {{(gpf_pkg::COL_W - gpf_pkg::MARGIN_W){1'b0}}, margin_r} +
                       gpf_pkg::NARROW_SLACK;
  assign settings_ok = (fill_r != '0) && (margin_r <= gpf_pkg::MARGIN_MAX) &&
                       !(justify_r &&
                         (margin_sum > {{(gpf_pkg::COL_W - gpf_pkg::LIMIT_W){1'b0}}, fill_r}));

  // The one adder and compare that decides whether the word stays on this line.
  assign fit_sum = {1'b0, col_r} + (gpf_pkg::COL_W + 1)'(1) +
                   {{(gpf_pkg::COL_W + 1 - gpf_pkg::LEN_W){1'b0}}, wlen_r};
  assign fits    = fit_sum <= {{(gpf_pkg::COL_W + 1 - gpf_pkg::LIMIT_W){1'b0}}, fill_r};

  assign word_we    = (state_r == S_IDLE) && in_fire && settings_ok && !is_sep &&
                      (wlen_r < gpf_pkg::LEN_W'(gpf_pkg::WORD_MAX));
  assign dot_needed = !justify_r && period_r;
  assign word_last  = (emit_idx_r + gpf_pkg::LEN_W'(1)) == wlen_r;

  always_comb begin
    emit_idx_nxt = emit_idx_r;
    if (state_r == S_IDLE) begin
      emit_idx_nxt = '0;
    end else if (state_r == S_WORD && out_free) begin
      emit_idx_nxt = emit_idx_r + gpf_pkg::LEN_W'(1);
    end
  end

  // The read address always tracks the next index, so the data register holds
  // the current word character whenever the word state is reached.
  always_ff @(posedge clk) begin
    if (word_we) begin
      word_mem[wlen_r[gpf_pkg::WORD_AW-1:0]] <= in_if.char_code;
    end
    rd_data_r <= word_mem[emit_idx_nxt[gpf_pkg::WORD_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= gpf_pkg::FILL_LIMIT_RST;
      justify_r   <= 1'b0;
      margin_r    <= gpf_pkg::MARGIN_WIDTH_RST;
      start_r     <= gpf_pkg::START_COLUMN_RST;
      wlen_r      <= '0;
      col_r       <= {1'b0, gpf_pkg::START_COLUMN_RST};
      first_r     <= 1'b1;
      period_r    <= 1'b0;
      pe_r        <= 1'b0;
      fits_r      <= 1'b0;
      mcnt_r      <= '0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      emit_idx_r <= emit_idx_nxt;
      if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_if.valid) begin
        unique case (cfg_if.reg_index)
          gpf_pkg::REG_FILL_LIMIT:   fill_r <= cfg_if.wr_data;
          gpf_pkg::REG_JUSTIFY_MODE: justify_r <= cfg_if.wr_data[0];
          gpf_pkg::REG_MARGIN_WIDTH: margin_r <= cfg_if.wr_data[gpf_pkg::MARGIN_W-1:0];
          gpf_pkg::REG_START_COLUMN: begin
            start_r <= cfg_if.wr_data;
            if (first_r && wlen_r == '0) begin
              col_r <= {1'b0, cfg_if.wr_data};
            end
          end
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            pe_r <= in_if.para_end;
            if (!settings_ok) begin
              pass_code_r <= line_end ? '0 : in_if.char_code;
              pass_nl_r   <= line_end;
              state_r     <= S_PASS;
            end else if (!is_sep) begin
              period_r <= (in_if.char_code == gpf_pkg::CH_DOT);
              if (word_we) begin
                wlen_r <= wlen_r + gpf_pkg::LEN_W'(1);
              end
            end else begin
              fits_r <= fits;
              if (wlen_r != '0) begin
                state_r <= S_LEAD;
              end else if (in_if.para_end) begin
                state_r <= S_PEND;
              end
            end
          end
        end

        S_PASS: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_code_r  <= pass_code_r;
            out_nl_r    <= pass_nl_r;
            out_last_r  <= 1'b1;
            if (pe_r) begin
              wlen_r   <= '0;
              col_r    <= {1'b0, start_r};
              first_r  <= 1'b1;
              period_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end

        S_LEAD: begin
          if (fits_r && first_r) begin
            // First word of a paragraph that fits: no leading space.
            first_r <= 1'b0;
            state_r <= S_WORD;
          end else if (out_free) begin
            out_valid_r <= 1'b1;
            out_last_r  <= 1'b0;
            first_r     <= 1'b0;
            if (fits_r) begin
              out_code_r <= gpf_pkg::CH_SPACE;
              out_nl_r   <= 1'b0;
              col_r      <= col_r + gpf_pkg::COL_W'(1);
              state_r    <= S_WORD;
            end else begin
              out_code_r <= '0;
              out_nl_r   <= 1'b1;
              col_r      <= '0;
              if (justify_r && margin_r != '0) begin
                mcnt_r  <= margin_r;
                state_r <= S_MARGIN;
              end else begin
                state_r <= S_WORD;
              end
            end
          end
        end

        S_MARGIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_code_r  <= gpf_pkg::CH_SPACE;
            out_nl_r    <= 1'b0;
            out_last_r  <= 1'b0;
            col_r       <= col_r + gpf_pkg::COL_W'(1);
            mcnt_r      <= mcnt_r - gpf_pkg::MARGIN_W'(1);
            if (mcnt_r == gpf_pkg::MARGIN_W'(1)) begin
              state_r <= S_WORD;
            end
          end
        end

        S_WORD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_code_r  <= rd_data_r;
            out_nl_r    <= 1'b0;
            out_last_r  <= word_last && !dot_needed && !pe_r;
            col_r       <= col_r + gpf_pkg::COL_W'(1);
            if (word_last) begin
              wlen_r <= '0;
              if (dot_needed) begin
                state_r <= S_DOT;
              end else if (pe_r) begin
                state_r <= S_PEND;
              end else begin
                state_r <= S_IDLE;
              end
            end
          end
        end

        S_DOT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_code_r  <= gpf_pkg::CH_SPACE;
            out_nl_r    <= 1'b0;
            out_last_r  <= !pe_r;
            col_r       <= col_r + gpf_pkg::COL_W'(1);
            state_r     <= pe_r ? S_PEND : S_IDLE;
          end
        end

        S_PEND: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_code_r  <= '0;
            out_nl_r    <= 1'b1;
            out_last_r  <= 1'b1;
            wlen_r      <= '0;
            col_r       <= {1'b0, start_r};
            first_r     <= 1'b1;
            period_r    <= 1'b0;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // A separator after a buffered word always starts its placement.
  a_sep_places_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && settings_ok && is_sep && wlen_r != '0) |=> (state_r == S_LEAD))
    else $error("separator after a word did not start placement");

  // The final newline of a paragraph restarts the paragraph state.
  a_pend_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PEND && out_free) |=>
      (state_r == S_IDLE && first_r && wlen_r == '0 && !period_r))
    else $error("paragraph end did not restart the paragraph");

  // No result is loaded while idle.
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && out_free) |=> !out_valid_r)
    else $error("result produced while idle");

  // The word buffer never holds more than its depth.
  a_wlen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (wlen_r == gpf_pkg::LEN_W'(gpf_pkg::WORD_MAX) && in_fire && !is_sep) |=>
      (wlen_r == gpf_pkg::LEN_W'(gpf_pkg::WORD_MAX)))
    else $error("word length grew past the buffer depth");
`endif

endmodule

FILE: test/greedy_paragraph_fill_test.sv
`timescale 1ns / 1ps

module greedy_paragraph_fill_test;

  localparam int MAX_RUN = 50;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 6;

  typedef struct packed {
    logic [gpf_pkg::CODE_W-1:0] code;
    logic                       line_end;
    logic                       para_end;
  } char_beat_t;

  typedef struct packed {
    logic [gpf_pkg::CODE_W-1:0] code;
    logic                       nl;
    logic                       last;
  } char_out_t;

  logic clk;
  logic rst_n;

  gpf_in_if  in_ch();
  gpf_out_if out_ch();
  gpf_cfg_if cfg_ch();

  greedy_paragraph_fill DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Shadow of the filler: settings and paragraph state.
  logic [gpf_pkg::LIMIT_W-1:0]  fill_col;
  logic                         justify_on;
  logic [gpf_pkg::MARGIN_W-1:0] margin_n;
  logic [gpf_pkg::LIMIT_W-1:0]  start_col;
  logic [gpf_pkg::CODE_W-1:0]   buffered_word [gpf_pkg::WORD_MAX];
  logic [gpf_pkg::LEN_W-1:0]    buffered_len;
  logic [gpf_pkg::COL_W-1:0]    cur_col;
  logic                         at_first_word;
  logic                         ends_in_period;

  char_beat_t  pending_chars [$];
  char_out_t   awaited_chars [$];
  char_out_t   held_out;
  char_beat_t  next_beat;
  char_beat_t  taken_beat;
  char_out_t   want;
  int          run_len;
  int          beats_sent;
  int          beats_taken;
  int          errors;
  int          send_gap_pct;
  int          recv_stall_pct;
  logic        rx_hold;
  logic        hold_go;
  int unsigned cycle_count = 0;

  // Results of one beat are held back by one so that the last can be marked.
  function automatic void emit_char(input logic [gpf_pkg::CODE_W-1:0] code, input logic nl);
    if (run_len >= MAX_RUN) return;
    if (run_len != 0) awaited_chars.push_back(held_out);
    held_out.code = nl ? '0 : code;
    held_out.nl   = nl;
    held_out.last = 1'b0;
    run_len++;
  endfunction

  function automatic void new_paragraph;
    buffered_len   = '0;
    cur_col        = gpf_pkg::COL_W'(start_col);
    at_first_word  = 1'b1;
    ends_in_period = 1'b0;
  endfunction

  function automatic logic fill_active;
    if (fill_col == 0 || margin_n > gpf_pkg::MARGIN_MAX) return 1'b0;
    if (justify_on && int'(margin_n) + int'(gpf_pkg::NARROW_SLACK) > int'(fill_col))
      return 1'b0;
    return 1'b1;
  endfunction

  function automatic void place_word;
    if (int'(cur_col) + 1 + int'(buffered_len) <= int'(fill_col)) begin
      if (!at_first_word) begin
        emit_char(gpf_pkg::CH_SPACE, 1'b0);
        cur_col++;
      end
    end else begin
      emit_char('0, 1'b1);
      cur_col = '0;
      if (justify_on) begin
        for (int i = 0; i < int'(margin_n); i++) emit_char(gpf_pkg::CH_SPACE, 1'b0);
        cur_col = gpf_pkg::COL_W'(margin_n);
      end
    end
    at_first_word = 1'b0;
    for (int i = 0; i < int'(buffered_len); i++)
      emit_char(buffered_word[i[gpf_pkg::WORD_AW-1:0]], 1'b0);
    cur_col = cur_col + gpf_pkg::COL_W'(buffered_len);
    if (!justify_on && ends_in_period) begin
      emit_char(gpf_pkg::CH_SPACE, 1'b0);
      cur_col++;
    end
    buffered_len = '0;
  endfunction

  function automatic void reflow_beat(input char_beat_t b);
    logic sep_end;
    sep_end = b.line_end | b.para_end;
    run_len = 0;
    if (!fill_active()) begin
      if (sep_end) emit_char('0, 1'b1);
      else emit_char(b.code, 1'b0);
      if (b.para_end) new_paragraph();
    end else if (!sep_end && b.code != gpf_pkg::CH_SPACE && b.code != gpf_pkg::CH_TAB) begin
      ends_in_period = (b.code == gpf_pkg::CH_DOT);
      if (buffered_len < gpf_pkg::WORD_MAX) begin
        buffered_word[buffered_len[gpf_pkg::WORD_AW-1:0]] = b.code;
        buffered_len++;
      end
    end else begin
      if (buffered_len != 0) place_word();
      if (b.para_end) begin
        emit_char('0, 1'b1);
        new_paragraph();
      end
    end
    if (run_len != 0) begin
      held_out.last = 1'b1;
      awaited_chars.push_back(held_out);
    end
  endfunction

  function automatic void apply_reg(input logic [gpf_pkg::CFG_IW-1:0] idx,
                                    input logic [gpf_pkg::CFG_DW-1:0] val);
    case (idx)
      gpf_pkg::REG_FILL_LIMIT:   fill_col = val;
      gpf_pkg::REG_JUSTIFY_MODE: justify_on = val[0];
      gpf_pkg::REG_MARGIN_WIDTH: margin_n = val[gpf_pkg::MARGIN_W-1:0];
      gpf_pkg::REG_START_COLUMN: begin
        start_col = val;
        // A new start column only moves the cursor of an untouched paragraph.
        if (at_first_word && buffered_len == 0) cur_col = gpf_pkg::COL_W'(val);
      end
      default: ;
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("greedy_paragraph_fill_test NOT OK");
      $finish;
    end
  end

  // Character driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        taken_beat.code     = in_ch.char_code;
        taken_beat.line_end = in_ch.line_end;
        taken_beat.para_end = in_ch.para_end;
        reflow_beat(taken_beat);
        beats_taken++;
      end
      if (pending_chars.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        next_beat = pending_chars.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.char_code <= next_beat.code;
        in_ch.line_end  <= next_beat.line_end;
        in_ch.para_end  <= next_beat.para_end;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_chars.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat code=%h nl=%b last=%b", $time,
                   out_ch.out_code, out_ch.is_newline, out_ch.last_of_run);
        end else begin
          want = awaited_chars.pop_front();
          if (out_ch.out_code !== want.code || out_ch.is_newline !== want.nl ||
              out_ch.last_of_run !== want.last) begin
            errors++;
            $display("%0t: expected code=%h nl=%b last=%b, got code=%h nl=%b last=%b",
                     $time, want.code, want.nl, want.last,
                     out_ch.out_code, out_ch.is_newline, out_ch.last_of_run);
          end
        end
      end
      out_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here once requested.
  initial begin
    rx_hold = 1'b0;
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic queue_beat(input logic [gpf_pkg::CODE_W-1:0] code, input logic le,
                            input logic pe);
    char_beat_t b;
    b.code     = code;
    b.line_end = le;
    b.para_end = pe;
    pending_chars.push_back(b);
    beats_sent++;
  endtask

  function automatic logic [gpf_pkg::CODE_W-1:0] word_char;
    logic [gpf_pkg::CODE_W-1:0] c;
    if ($urandom_range(7) != 0) return gpf_pkg::CODE_W'($urandom_range(126, 33));
    c = gpf_pkg::CODE_W'($urandom());
    if (c == gpf_pkg::CH_SPACE || c == gpf_pkg::CH_TAB) c = gpf_pkg::CH_DOT;
    return c;
  endfunction

  function automatic logic [gpf_pkg::CODE_W-1:0] noise_code;
    case ($urandom_range(3))
      0: return gpf_pkg::CH_SPACE;
      1: return gpf_pkg::CH_TAB;
      default: return gpf_pkg::CODE_W'($urandom());
    endcase
  endfunction

  // Mostly words with separators; a few stray beats and an odd long word.
  task automatic queue_text(input int target);
    int made;
    int wlen;
    int roll;
    made = 0;
    while (made < target) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        queue_beat(noise_code(), $urandom_range(3) == 0, $urandom_range(7) == 0);
        made++;
      end else begin
        wlen = ($urandom_range(24) == 0) ? $urandom_range(40, 30) : $urandom_range(7, 1);
        repeat (wlen) queue_beat(word_char(), 1'b0, 1'b0);
        made += wlen;
        if ($urandom_range(3) == 0) begin
          queue_beat(gpf_pkg::CH_DOT, 1'b0, 1'b0);
          made++;
        end
        roll = $urandom_range(19);
        if (roll < 10) queue_beat(gpf_pkg::CH_SPACE, 1'b0, 1'b0);
        else if (roll < 13) queue_beat(gpf_pkg::CH_TAB, 1'b0, 1'b0);
        else if (roll < 17) queue_beat(word_char(), 1'b1, 1'b0);
        else queue_beat(word_char(), 1'($urandom_range(1)), 1'b1);
        made++;
      end
    end
  endtask

  task automatic drain;
    while (beats_taken != beats_sent || awaited_chars.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(input logic [gpf_pkg::CFG_IW-1:0] idx,
                         input logic [gpf_pkg::CFG_DW-1:0] val);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data   <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, val);
  endtask

  task automatic configure(input int fill, input int just, input int margin, input int start);
    @(posedge clk);
    put_reg(gpf_pkg::REG_FILL_LIMIT, gpf_pkg::CFG_DW'(fill));
    put_reg(gpf_pkg::REG_JUSTIFY_MODE, gpf_pkg::CFG_DW'(just));
    put_reg(gpf_pkg::REG_MARGIN_WIDTH, gpf_pkg::CFG_DW'(margin));
    put_reg(gpf_pkg::REG_START_COLUMN, gpf_pkg::CFG_DW'(start));
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_gap_pct   = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.char_code  = '0;
    in_ch.line_end   = 1'b0;
    in_ch.para_end   = 1'b0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = gpf_pkg::REG_FILL_LIMIT;
    cfg_ch.wr_data   = '0;
    hold_go          = 1'b0;
    beats_sent       = 0;
    beats_taken      = 0;
    errors           = 0;
    run_len          = 0;
    held_out         = '0;
    fill_col         = gpf_pkg::FILL_LIMIT_RST;
    justify_on       = 1'b0;
    margin_n         = gpf_pkg::MARGIN_WIDTH_RST;
    start_col        = gpf_pkg::START_COLUMN_RST;
    foreach (buffered_word[i]) buffered_word[i] = '0;
    new_paragraph();
    set_idling(0, 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed beats under the reset settings.
    queue_beat(21'h61, 1'b0, 1'b0);
    queue_beat(gpf_pkg::CH_DOT, 1'b0, 1'b0);
    queue_beat(gpf_pkg::CH_SPACE, 1'b0, 1'b0);
    queue_beat(gpf_pkg::CH_TAB, 1'b0, 1'b0);
    queue_beat(21'h1FFFFF, 1'b0, 1'b0);
    queue_beat(21'h000000, 1'b0, 1'b0);
    queue_beat(21'h10FFFF, 1'b0, 1'b0);
    queue_beat(21'h78, 1'b1, 1'b0);
    queue_beat(21'h62, 1'b0, 1'b0);
    // Paragraph end without a line end acts as one.
    queue_beat(21'h71, 1'b0, 1'b1);
    queue_beat(gpf_pkg::CH_SPACE, 1'b1, 1'b0);
    queue_beat(21'h63, 1'b0, 1'b0);
    queue_beat(21'h0FFFFF, 1'b1, 1'b1);
    queue_beat(gpf_pkg::CH_TAB, 1'b1, 1'b1);
    queue_beat(21'h64, 1'b0, 1'b0);
    queue_beat(gpf_pkg::CH_DOT, 1'b0, 1'b0);
    queue_beat(gpf_pkg::CH_TAB, 1'b0, 1'b0);
    queue_beat(21'h65, 1'b0, 1'b0);
    queue_beat(gpf_pkg::CH_SPACE, 1'b0, 1'b1);
    drain();

    configure(20, 0, 0, 0);
    queue_text(40);
    drain();

    set_idling(73, 0);
    configure(255, 1, 16, 255);
    queue_text(60);
    drain();

    set_idling(0, 73);
    configure(12, 1, 2, 5);
    queue_text(60);
    drain();

    // Filling off, then two invalid margin settings: all pass straight through.
    set_idling(28, 28);
    configure(0, 0, 0, 9);
    queue_text(40);
    drain();

    set_idling(0, 0);
    configure(25, 1, 16, 0);
    queue_text(30);
    drain();

    configure(40, 0, 31, 0);
    queue_text(30);
    drain();

    // Every word wraps while the receiver holds off and the block backs up.
    configure(1, 0, 0, 0);
    hold_go = 1'b1;
    queue_text(60);
    drain();

    set_idling(28, 28);
    configure(30, 1, 0, 3);
    queue_text(60);
    drain();

    set_idling(0, 0);
    configure(72, 0, 8, 40);
    queue_text(40);
    drain();

    if (errors == 0) begin
      $display("greedy_paragraph_fill_test OK");
    end else begin
      $display("greedy_paragraph_fill_test NOT OK");
    end
    $finish;
  end

endmodule

FILE: greedy_paragraph_fill.f
rtl/gpf_pkg.sv
rtl/gpf_channels.sv
rtl/greedy_paragraph_fill.sv
test/greedy_paragraph_fill_test.sv
